// ----- rtl/core/bgd_pkg.sv -----
// Shared definitions for the button gesture decoder: timer width, event and
// gesture codes, configuration register indexes and the countdown load helper.
// No dependencies.
`timescale 1ns / 1ps

package bgd_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int INDEX_BITS = 1;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_BITS-1:0]   cfg_word_t;

    // event kinds
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_PRESS   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // gestures
    localparam logic [1:0] ACT_SLEEP = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_HOME  = 2'd2;
    localparam logic [1:0] ACT_POWER = 2'd3;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_DOUBLE_GAP = 1'd0;
    localparam logic [INDEX_BITS-1:0] REG_HOLD       = 1'd1;

    localparam cfg_word_t DOUBLE_GAP_RESET = CFG_BITS'(350);
    localparam cfg_word_t HOLD_RESET       = CFG_BITS'(5000);

    localparam logic [32:0] TIMER_MAX = (33'(1) << TIMER_BITS) - 33'(1);

    // Countdown preload, saturating when the timer is narrower than the register.
    function automatic timer_t timer_load(input cfg_word_t v);
        logic [32:0] wide;
        wide = 33'(v);
        if (wide > TIMER_MAX) begin
            return TIMER_MAX[TIMER_BITS-1:0];
        end
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/button_gesture_decoder_core.sv -----
// Button gesture decoder top level: countdown state, event decode and the
// result register. Depends on bgd_pkg.
`timescale 1ns / 1ps

// One transaction per cycle: every event (tick, press, release) is decoded in
// the cycle it is accepted, and any gesture it causes appears on the m_ channel
// on the next cycle from a single result register. s_ready is high whenever
// that register is empty or being drained in the same cycle, so the sustained
// rate is one event per clock while the output side keeps up. Ticks are one
// millisecond each; the hold and double-gap windows are counted in ticks from
// the configuration registers, and a press inside the gap window reports home.
module button_gesture_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bgd_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_BITS-1:0]   cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_mode,
    input  logic                           s_recording_active,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_action
);

    bgd_pkg::cfg_word_t double_gap_reg;
    bgd_pkg::cfg_word_t hold_ticks_reg;

    bgd_pkg::timer_t hold_count_reg, hold_count_next;
    bgd_pkg::timer_t gap_count_reg,  gap_count_next;
    logic hold_armed_reg,      hold_armed_next;
    logic gap_armed_reg,       gap_armed_next;
    logic hold_done_reg,       hold_done_next;
    logic awaiting_second_reg, awaiting_second_next;

    logic       out_valid_reg;
    logic [1:0] out_action_reg;

    logic       accept;
    logic       res_valid;
    logic [1:0] res_action;
    logic       hold_exp;
    logic       gap_exp;

    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_action = out_action_reg;

    assign hold_exp = hold_armed_reg && (hold_count_reg <= bgd_pkg::TIMER_BITS'(1));
    assign gap_exp  = gap_armed_reg && (gap_count_reg <= bgd_pkg::TIMER_BITS'(1));

    always_comb begin
        hold_count_next      = hold_count_reg;
        gap_count_next       = gap_count_reg;
        hold_armed_next      = hold_armed_reg;
        gap_armed_next       = gap_armed_reg;
        hold_done_next       = hold_done_reg;
        awaiting_second_next = awaiting_second_reg;
        res_valid            = 1'b0;
        res_action           = bgd_pkg::ACT_SLEEP;

        case (s_mode)
            bgd_pkg::MODE_TICK: begin
                if (hold_armed_reg) begin
                    if (hold_exp) begin
                        hold_count_next = '0;
                        hold_armed_next = 1'b0;
                    end else begin
                        hold_count_next = hold_count_reg - bgd_pkg::TIMER_BITS'(1);
                    end
                end
                if (gap_armed_reg) begin
                    if (gap_exp) begin
                        gap_count_next = '0;
                        gap_armed_next = 1'b0;
                    end else begin
                        gap_count_next = gap_count_reg - bgd_pkg::TIMER_BITS'(1);
                    end
                end
                // hold wins over a simultaneous gap expiry
                if (hold_exp) begin
                    hold_done_next       = 1'b1;
                    gap_armed_next       = 1'b0;
                    gap_count_next       = '0;
                    awaiting_second_next = 1'b0;
                    res_valid            = 1'b1;
                    res_action           = bgd_pkg::ACT_POWER;
                end else if (gap_exp) begin
                    awaiting_second_next = 1'b0;
                    res_valid            = 1'b1;
                    res_action           = s_recording_active ? bgd_pkg::ACT_MARK
                                                              : bgd_pkg::ACT_SLEEP;
                end
            end
            bgd_pkg::MODE_PRESS: begin
                hold_done_next = 1'b0;
                if (awaiting_second_reg) begin
                    gap_armed_next       = 1'b0;
                    gap_count_next       = '0;
                    hold_armed_next      = 1'b0;
                    hold_count_next      = '0;
                    awaiting_second_next = 1'b0;
                    res_valid            = 1'b1;
                    res_action           = bgd_pkg::ACT_HOME;
                end else begin
                    hold_count_next = bgd_pkg::timer_load(hold_ticks_reg);
                    hold_armed_next = 1'b1;
                end
            end
            bgd_pkg::MODE_RELEASE: begin
                hold_armed_next = 1'b0;
                hold_count_next = '0;
                if (hold_done_reg) begin
                    // release that ends a long press is swallowed
                    hold_done_next = 1'b0;
                end else begin
                    awaiting_second_next = 1'b1;
                    gap_count_next       = bgd_pkg::timer_load(double_gap_reg);
                    gap_armed_next       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_gap_reg      <= bgd_pkg::DOUBLE_GAP_RESET;
            hold_ticks_reg      <= bgd_pkg::HOLD_RESET;
            hold_count_reg      <= '0;
            gap_count_reg       <= '0;
            hold_armed_reg      <= 1'b0;
            gap_armed_reg       <= 1'b0;
            hold_done_reg       <= 1'b0;
            awaiting_second_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bgd_pkg::REG_DOUBLE_GAP: double_gap_reg <= cfg_wdata;
                    bgd_pkg::REG_HOLD:       hold_ticks_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                hold_count_reg      <= hold_count_next;
                gap_count_reg       <= gap_count_next;
                hold_armed_reg      <= hold_armed_next;
                gap_armed_reg       <= gap_armed_next;
                hold_done_reg       <= hold_done_next;
                awaiting_second_reg <= awaiting_second_next;
                out_valid_reg       <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_action_reg <= res_action;
        end
    end

`ifndef SYNTHESIS
    // a pending single always has its gap countdown running
    a_gap_tracks_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_armed_reg == awaiting_second_reg)
        else $error("gap countdown and pending single disagree");

    // once the hold has fired its countdown is no longer running
    a_hold_done_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_done_reg |-> !hold_armed_reg)
        else $error("hold countdown still armed after firing");

    // a press inside the double window reports home on the next cycle
    a_double_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == bgd_pkg::MODE_PRESS && awaiting_second_reg)
        |=> (m_valid && m_action == bgd_pkg::ACT_HOME))
        else $error("double press did not report home");
`endif

endmodule
